>>> src/iaie_pkg.sv
// ----------------------------------------------------------------------------
// Indexed array insert/erase package
// Shared widths, request and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package iaie_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int CMD_W        = 3;
  localparam int POS_W        = 5;
  localparam int VAL_W        = 32;
  localparam int ST_W         = 2;
  localparam int CNT_OUT_W    = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP,
    OP_INSERT,
    OP_ERASE,
    OP_READ,
    OP_WRITE
  } arr_op_t;

  typedef struct packed {
    logic            fire;
    arr_op_t         op;
    logic [ST_W-1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic pos_lt_cnt;
    logic pos_le_cnt;
    logic cnt_zero;
    logic cnt_full;
  } dp_stat_t;

endpackage

>>> src/iaie_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed array controller
// Decodes each request against the array status, selects the operation and
// its status code, and tracks whether a result is waiting at the output.
// ----------------------------------------------------------------------------
module iaie_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [iaie_pkg::CMD_W-1:0]   in_command,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  iaie_pkg::dp_stat_t           stat,
  output iaie_pkg::dp_cmd_t            cmd
);
  import iaie_pkg::*;

  typedef enum logic {
    S_EMPTY,
    S_HOLD
  } state_t;

  state_t          state_r;
  state_t          state_nxt;
  logic            accept;
  arr_op_t         op;
  logic [ST_W-1:0] status;

  assign in_ready  = (state_r == S_EMPTY) || out_ready;
  assign out_valid = (state_r == S_HOLD);
  assign accept    = in_valid && in_ready;

  always_comb begin
    op     = OP_NONE;
    status = ST_RANGE;
    unique case (in_command)
      CMD_PUSH: begin
        if (stat.cnt_full) begin
          status = ST_FULL;
        end else begin
          status = ST_OK;
          op     = OP_PUSH;
        end
      end
      CMD_POP: begin
        if (!stat.cnt_zero) begin
          status = ST_OK;
          op     = OP_POP;
        end
      end
      CMD_INSERT: begin
        if (!stat.pos_le_cnt) begin
          status = ST_RANGE;
        end else if (stat.cnt_full) begin
          status = ST_FULL;
        end else begin
          status = ST_OK;
          op     = OP_INSERT;
        end
      end
      CMD_ERASE: begin
        if (stat.pos_lt_cnt) begin
          status = ST_OK;
          op     = OP_ERASE;
        end
      end
      CMD_READ: begin
        if (stat.pos_lt_cnt) begin
          status = ST_OK;
          op     = OP_READ;
        end
      end
      CMD_WRITE: begin
        if (stat.pos_lt_cnt) begin
          status = ST_OK;
          op     = OP_WRITE;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  assign cmd.fire   = accept;
  assign cmd.op     = op;
  assign cmd.status = status;

  always_comb begin
    state_nxt = state_r;
    priority if (accept) begin
      state_nxt = S_HOLD;
    end else if (out_ready) begin
      state_nxt = S_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/iaie_dp.sv
// ----------------------------------------------------------------------------
// Indexed array datapath
// A row of entry cells that write, shift up or shift down together, the
// entry count, the position compares and the result registers.
// ----------------------------------------------------------------------------
module iaie_dp #(
  parameter int CAPACITY = iaie_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  iaie_pkg::dp_cmd_t               cmd,
  output iaie_pkg::dp_stat_t              stat,
  input  logic [iaie_pkg::POS_W-1:0]      position,
  input  logic signed [iaie_pkg::VAL_W-1:0] value,
  output logic signed [iaie_pkg::VAL_W-1:0] out_read_value,
  output logic [iaie_pkg::ST_W-1:0]       out_status,
  output logic [iaie_pkg::CNT_OUT_W-1:0]  out_count
);
  import iaie_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int W     = (CW > POS_W) ? CW : POS_W;

  logic signed [VAL_W-1:0] cells_r   [CAPACITY];
  logic signed [VAL_W-1:0] cells_nxt [CAPACITY];
  logic [CW-1:0]           cnt_r;
  logic [CW-1:0]           cnt_nxt;
  logic [W-1:0]            pos_w;
  logic [W-1:0]            cnt_w;
  logic [W-1:0]            cnt_nxt_w;
  logic [IDX_W-1:0]        rd_idx;
  logic signed [VAL_W-1:0] rd_val;
  logic signed [VAL_W-1:0] out_read_value_r;
  logic [ST_W-1:0]         out_status_r;
  logic [CNT_OUT_W-1:0]    out_count_r;

  assign pos_w  = W'(position);
  assign cnt_w  = W'(cnt_r);
  assign rd_idx = pos_w[IDX_W-1:0];
  assign rd_val = cells_r[rd_idx];

  assign stat.pos_lt_cnt = pos_w < cnt_w;
  assign stat.pos_le_cnt = pos_w <= cnt_w;
  assign stat.cnt_zero   = cnt_r == '0;
  assign stat.cnt_full   = cnt_r == CW'(CAPACITY);

  always_comb begin
    cnt_nxt = cnt_r;
    unique case (cmd.op)
      OP_PUSH, OP_INSERT: cnt_nxt = cnt_r + CW'(1);
      OP_POP, OP_ERASE:   cnt_nxt = cnt_r - CW'(1);
      default:            cnt_nxt = cnt_r;
    endcase
  end

  assign cnt_nxt_w = W'(cnt_nxt);

  always_comb begin
    logic [W-1:0] iw;
    for (int i = 0; i < CAPACITY; i++) begin
      iw           = W'(i);
      cells_nxt[i] = cells_r[i];
      unique case (cmd.op)
        OP_PUSH: begin
          if (iw == cnt_w) begin
            cells_nxt[i] = value;
          end
        end
        OP_INSERT: begin
          if (iw == pos_w) begin
            cells_nxt[i] = value;
          end else if ((i > 0) && (iw > pos_w)) begin
            cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
          end
        end
        OP_ERASE: begin
          if ((i + 1 < CAPACITY) && (iw >= pos_w)) begin
            cells_nxt[i] = cells_r[(i + 1 < CAPACITY) ? i + 1 : i];
          end
        end
        OP_WRITE: begin
          if (iw == pos_w) begin
            cells_nxt[i] = value;
          end
        end
        default: begin
          cells_nxt[i] = cells_r[i];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cells_r[i] <= cells_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.fire) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      out_read_value_r <= (cmd.op == OP_READ) ? rd_val : '0;
      out_status_r     <= cmd.status;
      out_count_r      <= cnt_nxt_w[CNT_OUT_W-1:0];
    end
  end

  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;

endmodule

>>> src/indexed_array_insert_erase_unit.sv
// ----------------------------------------------------------------------------
// Indexed array insert/erase unit
// Ordered array of signed words with push, pop, insert, erase, read and write.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel as a command, a position and a value.
// Each request returns one result on the out_ channel: the value read (zero
// unless a read succeeds), a status (ok, out of range or empty, full) and the
// entry count after the request. A request that fails changes nothing.
// The result is registered and appears in the cycle after the request is
// accepted. All entries sit in a row of cells that write and shift together,
// so every command completes in one update of the cells and the unit takes
// one request per cycle while out_ready is high.
// The result register decouples the sides: a new request is taken in the
// same cycle that the pending result is taken. While the receiver stalls,
// the result holds and in_ready stays low.
// Reset empties the array and drops any pending result; entry contents are
// not cleared, since only positions below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_array_insert_erase_unit #(
  parameter int CAPACITY = iaie_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [iaie_pkg::CMD_W-1:0]        in_command,
  input  logic [iaie_pkg::POS_W-1:0]        in_position,
  input  logic signed [iaie_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [iaie_pkg::VAL_W-1:0] out_read_value,
  output logic [iaie_pkg::ST_W-1:0]         out_status,
  output logic [iaie_pkg::CNT_OUT_W-1:0]    out_count
);
  import iaie_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  iaie_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  iaie_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .position       (in_position),
    .value          (in_value),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_count      (out_count)
  );

endmodule

>>> src/iaie_checker.sv
// ----------------------------------------------------------------------------
// Indexed array port checker
// Watches the ports of the unit and flags results that break its contract.
// ----------------------------------------------------------------------------
module iaie_checker #(
  parameter int CAPACITY = iaie_pkg::CAPACITY_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [iaie_pkg::VAL_W-1:0] out_read_value,
  input logic [iaie_pkg::ST_W-1:0]         out_status,
  input logic [iaie_pkg::CNT_OUT_W-1:0]    out_count
);
  import iaie_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1) + CNT_OUT_W;
  localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);
  localparam logic [CNT_OUT_W-1:0] CAP_LOW = CAP_W[CNT_OUT_W-1:0];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value)
      && $stable(out_status) && $stable(out_count))
    else $error("Result changed while stalled.");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("Accepted request produced no result.");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_read_value == '0)
    else $error("Failed request returned a nonzero read value.");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_count == CAP_LOW)
    else $error("Full status with a count below capacity.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_RANGE
      || out_status == ST_FULL)
    else $error("Unknown status code.");

endmodule

bind indexed_array_insert_erase_unit iaie_checker #(.CAPACITY(CAPACITY)) u_iaie_checker (.*);
